// File: src/ncc_pkg.sv
// ----------------------------------------------------------------------------
// ncc_pkg
// Shared types, constants and helpers for the nearest centroid classifier.
// ----------------------------------------------------------------------------
package ncc_pkg;

  // Block sizing
  localparam int DIMENSIONS   = 4;
  localparam int MAX_CLUSTERS = 8;
  localparam int COORD_BITS   = 16;

  // Coordinate fields that exist on the input item
  localparam int FIELD_COORDS = 4;
  // Slots addressable by the 3-bit slot field
  localparam int SLOT_SPAN    = 8;

  localparam int USED_DIMS   = (DIMENSIONS < FIELD_COORDS) ? DIMENSIONS : FIELD_COORDS;
  localparam int TABLE_DEPTH = (MAX_CLUSTERS < SLOT_SPAN) ? MAX_CLUSTERS : SLOT_SPAN;
  localparam int CLUSTER_W   = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int DIM_W       = (USED_DIMS > 1) ? $clog2(USED_DIMS) : 1;
  localparam int SQ_W        = 2 * COORD_BITS;
  localparam int DIST_W      = 34;
  localparam int CENT_W      = USED_DIMS * COORD_BITS;

  // Operation codes
  localparam logic OP_LOAD     = 1'b0;
  localparam logic OP_CLASSIFY = 1'b1;

  typedef struct packed {
    logic               operation;
    logic [2:0]         cluster_slot;
    logic signed [15:0] coord_0;
    logic signed [15:0] coord_1;
    logic signed [15:0] coord_2;
    logic signed [15:0] coord_3;
    logic [15:0]        point_index;
  } in_item_t;

  typedef struct packed {
    logic [15:0]       point_tag;
    logic [2:0]        nearest_cluster;
    logic [DIST_W-1:0] min_sq_distance;
  } out_item_t;

  // Coordinates as used by the datapath, low COORD_BITS of each field
  typedef logic [USED_DIMS-1:0][COORD_BITS-1:0] point_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FETCH,
    ST_START,
    ST_WAIT,
    ST_EMIT
  } seq_state_t;

  // Gather the used coordinates of an item into one vector
  function automatic point_t point_of(in_item_t item);
    logic [FIELD_COORDS-1:0][15:0] raw;
    point_t                        p;
    raw[0] = item.coord_0;
    raw[1] = item.coord_1;
    raw[2] = item.coord_2;
    raw[3] = item.coord_3;
    for (int d = 0; d < USED_DIMS; d++) begin
      p[d] = raw[d][COORD_BITS-1:0];
    end
    return p;
  endfunction

endpackage

// File: src/ncc_ram.sv
// ----------------------------------------------------------------------------
// ncc_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module ncc_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 8
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                      wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// File: src/ncc_dist.sv
// ----------------------------------------------------------------------------
// ncc_dist
// Shared squared-distance unit: one subtract and square per cycle, one
// dimension at a time, summed into a running accumulator.
// ----------------------------------------------------------------------------
module ncc_dist (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  ncc_pkg::point_t           point,
  input  ncc_pkg::point_t           centroid,
  output logic                      done,
  output logic [ncc_pkg::DIST_W-1:0] sum
);

  logic                              running;
  logic [ncc_pkg::DIM_W-1:0]         dim;
  logic                              sq_valid;
  logic                              sq_last;
  logic [ncc_pkg::SQ_W-1:0]          sq;
  logic [ncc_pkg::DIST_W-1:0]        acc;
  logic signed [ncc_pkg::COORD_BITS:0]     diff;
  logic signed [2*ncc_pkg::COORD_BITS+1:0] prod;
  logic                              dim_last;

  // Difference and square of the current dimension
  always_comb begin
    diff = $signed({point[dim][ncc_pkg::COORD_BITS-1], point[dim]})
         - $signed({centroid[dim][ncc_pkg::COORD_BITS-1], centroid[dim]});
    prod = diff * diff;
    dim_last = (dim == ncc_pkg::DIM_W'(ncc_pkg::USED_DIMS - 1));
  end

  // Advance through the dimensions
  always_ff @(posedge clk) begin
    if (rst) begin
      running  <= 1'b0;
      dim      <= '0;
      sq_valid <= 1'b0;
      sq_last  <= 1'b0;
    end else begin
      sq_valid <= running;
      sq_last  <= running && dim_last;
      if (start) begin
        running <= 1'b1;
        dim     <= '0;
      end else if (running) begin
        if (dim_last) begin
          running <= 1'b0;
        end else begin
          dim <= dim + 1'b1;
        end
      end
    end
  end

  // Hold the square of each dimension
  always_ff @(posedge clk) begin
    sq <= prod[ncc_pkg::SQ_W-1:0];
  end

  // Accumulate and flag the finished sum
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= sq_valid && sq_last;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      acc <= '0;
    end else if (sq_valid) begin
      acc <= acc + ncc_pkg::DIST_W'(sq);
    end
  end

  assign sum = acc;

endmodule

// File: src/nearest_centroid_classifier_unit.sv
// ----------------------------------------------------------------------------
// nearest_centroid_classifier_unit
// K-means assignment: holds a centroid table and returns the nearest active
// centroid and its squared distance for each classified point.
// ----------------------------------------------------------------------------
// Load item: written straight into the table, no result.
// Classify item: result strobed after every active centroid has been checked;
//   each centroid goes through the single subtract-and-square unit one
//   dimension per cycle, plus table read and sum.
// busy stays high until the result cycle is over; results cannot be stalled.
// Synchronous reset sets k to 1; the centroid table is undefined until loaded.
// ----------------------------------------------------------------------------
module nearest_centroid_classifier_unit (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  ncc_pkg::in_item_t  cmd,
  output logic               busy,
  output logic               done,
  output ncc_pkg::out_item_t result,
  input  logic               cfg_we,
  input  logic [3:0]         cfg_data
);

  ncc_pkg::seq_state_t          state;
  ncc_pkg::seq_state_t          state_next;
  logic [3:0]                   cluster_count;
  logic [ncc_pkg::CLUSTER_W-1:0] cluster;
  logic [ncc_pkg::CLUSTER_W-1:0] last_cluster;
  logic [ncc_pkg::CLUSTER_W-1:0] k_last;
  ncc_pkg::point_t              point;
  logic [15:0]                  tag;
  logic [ncc_pkg::CLUSTER_W-1:0] best_cluster;
  logic [ncc_pkg::DIST_W-1:0]   best_dist;
  logic                         accept;
  logic                         load_we;
  logic                         dist_start;
  logic                         dist_done;
  logic [ncc_pkg::DIST_W-1:0]   dist_sum;
  logic [ncc_pkg::CENT_W-1:0]   cent_raw;
  ncc_pkg::point_t              centroid;

  assign accept = start && !busy;

  // Clamp k into 1 .. table depth
  always_comb begin
    if (cluster_count == 4'd0) begin
      k_last = '0;
    end else if (32'(cluster_count) > ncc_pkg::TABLE_DEPTH) begin
      k_last = ncc_pkg::CLUSTER_W'(ncc_pkg::TABLE_DEPTH - 1);
    end else begin
      k_last = ncc_pkg::CLUSTER_W'(cluster_count - 4'd1);
    end
  end

  // Cluster count register
  always_ff @(posedge clk) begin
    if (rst) begin
      cluster_count <= 4'd1;
    end else if (cfg_we) begin
      cluster_count <= cfg_data;
    end
  end

  // Load items write the table directly
  assign load_we = accept && (cmd.operation == ncc_pkg::OP_LOAD)
                && (32'(cmd.cluster_slot) < ncc_pkg::TABLE_DEPTH);

  ncc_ram #(
    .WIDTH (ncc_pkg::CENT_W),
    .DEPTH (ncc_pkg::TABLE_DEPTH)
  ) u_table (
    .clk   (clk),
    .we    (load_we),
    .waddr (ncc_pkg::CLUSTER_W'(cmd.cluster_slot)),
    .wdata (ncc_pkg::point_of(cmd)),
    .raddr (cluster),
    .rdata (cent_raw)
  );

  assign centroid = cent_raw;

  ncc_dist u_dist (
    .clk      (clk),
    .rst      (rst),
    .start    (dist_start),
    .point    (point),
    .centroid (centroid),
    .done     (dist_done),
    .sum      (dist_sum)
  );

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      ncc_pkg::ST_IDLE: begin
        if (accept && (cmd.operation == ncc_pkg::OP_CLASSIFY)) begin
          state_next = ncc_pkg::ST_FETCH;
        end
      end
      ncc_pkg::ST_FETCH: state_next = ncc_pkg::ST_START;
      ncc_pkg::ST_START: state_next = ncc_pkg::ST_WAIT;
      ncc_pkg::ST_WAIT: begin
        if (dist_done) begin
          state_next = (cluster == last_cluster) ? ncc_pkg::ST_EMIT : ncc_pkg::ST_FETCH;
        end
      end
      ncc_pkg::ST_EMIT: state_next = ncc_pkg::ST_IDLE;
      default: state_next = ncc_pkg::ST_IDLE;
    endcase
  end

  // Outputs of the sequencer
  always_comb begin
    busy       = 1'b1;
    done       = 1'b0;
    dist_start = 1'b0;
    case (state)
      ncc_pkg::ST_IDLE:  busy = 1'b0;
      ncc_pkg::ST_START: dist_start = 1'b1;
      ncc_pkg::ST_EMIT:  done = 1'b1;
      default: begin
        busy = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ncc_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Latch the point and step the centroid counter
  always_ff @(posedge clk) begin
    if (rst) begin
      cluster      <= '0;
      last_cluster <= '0;
    end else if (state == ncc_pkg::ST_IDLE) begin
      cluster      <= '0;
      last_cluster <= k_last;
    end else if ((state == ncc_pkg::ST_WAIT) && dist_done && (cluster != last_cluster)) begin
      cluster <= cluster + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      point <= ncc_pkg::point_of(cmd);
      tag   <= cmd.point_index;
    end
  end

  // Keep the nearest centroid; strict compare leaves ties on the lower index
  always_ff @(posedge clk) begin
    if ((state == ncc_pkg::ST_WAIT) && dist_done) begin
      if ((cluster == '0) || (dist_sum < best_dist)) begin
        best_dist    <= dist_sum;
        best_cluster <= cluster;
      end
    end
  end

  always_comb begin
    result.point_tag       = tag;
    result.nearest_cluster = 3'(best_cluster);
    result.min_sq_distance = best_dist;
  end

endmodule
